>>> hw/rtl/temporal_index_stream_decoder_unit_macros.svh
// Assertion macros of the temporal index decoder RTL
`ifndef TEMPORAL_INDEX_STREAM_DECODER_UNIT_MACROS_SVH
`define TEMPORAL_INDEX_STREAM_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define TIDSD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define TIDSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/tidsd_pkg.sv
// Types, codes and constants of the temporal index stream decoder
package tidsd_pkg;

    // Depth of the queue between the front and the parser
    localparam int QUEUE_DEPTH = 2;

    // Buffer format
    localparam int          MAGIC_BYTES = 8;
    localparam int          HEAD_BYTES  = 16;
    localparam int          FHDR_BYTES  = 12;
    localparam logic [31:0] NANO_MAX    = 32'd999999999;
    localparam logic [31:0] VERSION_ONE = 32'd1;

    localparam logic [7:0] MAGIC [MAGIC_BYTES] = '{
        8'h4C, 8'h43, 8'h50, 8'h54, 8'h4D, 8'h50, 8'h31, 8'h00
    };

    // Parser phase
    typedef enum logic [2:0] {
        PH_HEAD,
        PH_FHDR,
        PH_NAME,
        PH_VALUE,
        PH_RESID,
        PH_DONE,
        PH_ERROR
    } t_phase;

    // Result kind
    typedef enum logic [2:0] {
        KIND_NAME   = 3'd0,
        KIND_VALUE  = 3'd1,
        KIND_RESID  = 3'd2,
        KIND_FHDR   = 3'd3,
        KIND_STATUS = 3'd4
    } t_kind;

    // Final status
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_MAGIC   = 3'd1,
        ST_BAD_VERSION = 3'd2,
        ST_TRUNCATED   = 3'd3,
        ST_BAD_NANOS   = 3'd4,
        ST_TRAILING    = 3'd5
    } t_status;

    // One input beat as held in the queue
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_in_beat;

    // Queue head as seen by the parser
    typedef struct packed {
        logic     valid;
        t_in_beat beat;
    } t_queue_head;

endpackage

>>> hw/rtl/tidsd_ifs.sv
// Valid/ready stream interfaces for the decoder input and result channels

interface tidsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface tidsd_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [31:0]        field_number;
    logic [7:0]         name_char;
    logic signed [63:0] seconds;
    logic [29:0]        nanos;
    logic [31:0]        document;
    logic               done_res;
    logic [2:0]         status;

    modport source (
        output valid, output kind, output field_number, output name_char,
        output seconds, output nanos, output document, output done_res,
        output status, input ready
    );
    modport sink (
        input valid, input kind, input field_number, input name_char,
        input seconds, input nanos, input document, input done_res,
        input status, output ready
    );
endinterface

>>> hw/rtl/tidsd_queue.sv
// Front: accepts input beats into a short queue ahead of the parser
module tidsd_queue #(
    parameter int Depth = tidsd_pkg::QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    tidsd_in_if.sink               i_in,
    input  logic                   i_pop,
    output tidsd_pkg::t_queue_head o_head
);

    localparam int              PtrW    = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int              CntW    = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] Full    = CntW'(Depth);

    tidsd_pkg::t_in_beat r_mem [Depth];
    logic [PtrW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]     r_count, n_count;
    logic                push;
    logic                pop;

    // Handshake
    assign i_in.ready = (r_count != Full);
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_pop && (r_count != '0);

    // Head of queue
    assign o_head.valid = (r_count != '0);
    assign o_head.beat  = r_mem[r_rd_ptr];

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + PtrW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + PtrW'(1);
        end
        case ({push, pop})
            2'b10:   n_count = r_count + CntW'(1);
            2'b01:   n_count = r_count - CntW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= '{data_byte: i_in.data_byte, end_of_buffer: i_in.end_of_buffer};
        end
    end

endmodule

>>> hw/rtl/tidsd_back.sv
// Back: byte-serial parser of the index format with a registered result stage
`include "temporal_index_stream_decoder_unit_macros.svh"

module tidsd_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tidsd_pkg::t_queue_head i_head,
    output logic                   o_pop,
    tidsd_out_if.source            o_out
);

    // Byte positions inside each section
    localparam logic [4:0] MagicEnd    = 5'(tidsd_pkg::MAGIC_BYTES);
    localparam logic [4:0] VersionLast = 5'd11;
    localparam logic [4:0] CountLast   = 5'(tidsd_pkg::HEAD_BYTES - 1);
    localparam logic [4:0] NameLenLast = 5'd3;
    localparam logic [4:0] ValCntLast  = 5'd7;
    localparam logic [4:0] FhdrLast    = 5'(tidsd_pkg::FHDR_BYTES - 1);
    localparam logic [4:0] SecLast     = 5'd7;
    localparam logic [4:0] NanosLast   = 5'd11;
    localparam logic [4:0] ValueLast   = 5'd15;
    localparam logic [4:0] DocLast     = 5'd3;

    typedef struct packed {
        tidsd_pkg::t_kind   kind;
        logic [31:0]        field_number;
        logic [7:0]         name_char;
        logic signed [63:0] seconds;
        logic [29:0]        nanos;
        logic [31:0]        document;
        logic               done_res;
        tidsd_pkg::t_status status;
    } t_out_beat;

    tidsd_pkg::t_phase  r_phase, n_phase;
    logic [4:0]         r_pos, n_pos;
    logic [63:0]        r_shift, n_shift;
    logic [31:0]        r_fields, n_fields;
    logic [31:0]        r_names, n_names;
    logic [31:0]        r_values, n_values;
    logic [31:0]        r_resids, n_resids;
    logic [31:0]        r_cur, n_cur;
    tidsd_pkg::t_status r_err, n_err;
    logic [63:0]        r_hsec, n_hsec;
    logic [31:0]        r_hnan, n_hnan;
    logic               r_out_valid;
    t_out_beat          r_out, res;

    logic               step;
    logic [7:0]         b;
    logic               last;
    logic [31:0]        word;
    logic               nanos_bad;
    logic               emit;

    // Beat taken from the queue whenever the result register can be refilled
    assign step  = i_head.valid && (!r_out_valid || o_out.ready);
    assign o_pop = step;
    assign b     = i_head.beat.data_byte;
    assign last  = i_head.beat.end_of_buffer;

    // Little-endian assembly shifts bytes in from the top
    assign n_shift   = (r_phase != tidsd_pkg::PH_ERROR && r_phase != tidsd_pkg::PH_DONE)
                       ? {b, r_shift[63:8]} : r_shift;
    assign word      = n_shift[63:32];
    assign nanos_bad = (r_hnan > tidsd_pkg::NANO_MAX);

    // Next state
    always_comb begin
        logic adv;
        logic chk_name;
        logic chk_value;
        logic chk_resid;

        adv       = 1'b0;
        chk_name  = 1'b0;
        chk_value = 1'b0;
        chk_resid = 1'b0;
        n_phase   = r_phase;
        n_pos     = r_pos + 5'd1;
        n_fields  = r_fields;
        n_names   = r_names;
        n_values  = r_values;
        n_resids  = r_resids;
        n_cur     = r_cur;
        n_err     = r_err;
        n_hsec    = r_hsec;
        n_hnan    = r_hnan;

        unique case (r_phase)
            tidsd_pkg::PH_HEAD: begin
                if (r_pos < MagicEnd) begin
                    if (b != tidsd_pkg::MAGIC[r_pos[2:0]]) begin
                        n_err   = tidsd_pkg::ST_BAD_MAGIC;
                        n_phase = tidsd_pkg::PH_ERROR;
                    end
                end else if (r_pos == VersionLast) begin
                    if (word != tidsd_pkg::VERSION_ONE) begin
                        n_err   = tidsd_pkg::ST_BAD_VERSION;
                        n_phase = tidsd_pkg::PH_ERROR;
                    end
                end else if (r_pos >= CountLast) begin
                    n_fields = word;
                    n_cur    = '0;
                    n_pos    = '0;
                    n_phase  = (word != '0) ? tidsd_pkg::PH_FHDR : tidsd_pkg::PH_DONE;
                end
            end
            tidsd_pkg::PH_FHDR: begin
                if (r_pos == NameLenLast) begin
                    n_names = word;
                end else if (r_pos == ValCntLast) begin
                    n_values = word;
                end else if (r_pos >= FhdrLast) begin
                    n_resids  = word;
                    adv       = 1'b1;
                    chk_name  = 1'b1;
                    chk_value = 1'b1;
                    chk_resid = 1'b1;
                end
            end
            tidsd_pkg::PH_NAME: begin
                n_names = r_names - 32'd1;
                if (n_names == '0) begin
                    adv       = 1'b1;
                    chk_value = 1'b1;
                    chk_resid = 1'b1;
                end
            end
            tidsd_pkg::PH_VALUE: begin
                if (r_pos == SecLast) begin
                    n_hsec = n_shift;
                end else if (r_pos == NanosLast) begin
                    n_hnan = word;
                end else if (r_pos >= ValueLast) begin
                    n_pos = '0;
                    if (nanos_bad) begin
                        n_err   = tidsd_pkg::ST_BAD_NANOS;
                        n_phase = tidsd_pkg::PH_ERROR;
                    end else begin
                        n_values = r_values - 32'd1;
                        if (n_values == '0) begin
                            adv       = 1'b1;
                            chk_resid = 1'b1;
                        end
                    end
                end
            end
            tidsd_pkg::PH_RESID: begin
                if (r_pos >= DocLast) begin
                    n_pos    = '0;
                    n_resids = r_resids - 32'd1;
                    if (n_resids == '0) begin
                        adv = 1'b1;
                    end
                end
            end
            tidsd_pkg::PH_DONE: begin
                n_err   = tidsd_pkg::ST_TRAILING;
                n_phase = tidsd_pkg::PH_ERROR;
            end
            tidsd_pkg::PH_ERROR: begin
                n_phase = r_phase;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        // Enter the next non-empty section of the field, or the next field
        if (adv) begin
            n_pos = '0;
            if (chk_name && n_names != '0) begin
                n_phase = tidsd_pkg::PH_NAME;
            end else if (chk_value && n_values != '0) begin
                n_phase = tidsd_pkg::PH_VALUE;
            end else if (chk_resid && n_resids != '0) begin
                n_phase = tidsd_pkg::PH_RESID;
            end else begin
                n_cur    = r_cur + 32'd1;
                n_fields = r_fields - 32'd1;
                n_phase  = (n_fields != '0) ? tidsd_pkg::PH_FHDR : tidsd_pkg::PH_DONE;
            end
        end
    end

    // Result of the current beat
    always_comb begin
        emit = 1'b0;
        res  = '{kind: tidsd_pkg::KIND_STATUS, status: tidsd_pkg::ST_OK, default: '0};

        unique case (r_phase)
            tidsd_pkg::PH_FHDR: begin
                if (r_pos >= FhdrLast) begin
                    emit             = 1'b1;
                    res.kind         = tidsd_pkg::KIND_FHDR;
                    res.field_number = r_cur;
                end
            end
            tidsd_pkg::PH_NAME: begin
                emit             = 1'b1;
                res.kind         = tidsd_pkg::KIND_NAME;
                res.field_number = r_cur;
                res.name_char    = b;
            end
            tidsd_pkg::PH_VALUE: begin
                if (r_pos >= ValueLast && !nanos_bad) begin
                    emit             = 1'b1;
                    res.kind         = tidsd_pkg::KIND_VALUE;
                    res.field_number = r_cur;
                    // zigzag decode
                    res.seconds      = {1'b0, r_hsec[63:1]} ^ {64{r_hsec[0]}};
                    res.nanos        = r_hnan[29:0];
                    res.document     = word;
                end
            end
            tidsd_pkg::PH_RESID: begin
                if (r_pos >= DocLast) begin
                    emit             = 1'b1;
                    res.kind         = tidsd_pkg::KIND_RESID;
                    res.field_number = r_cur;
                    res.document     = word;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase

        // Final beat carries the status
        if (last) begin
            res.done_res = 1'b1;
            if (n_err != tidsd_pkg::ST_OK) begin
                res.status = n_err;
            end else if (n_phase == tidsd_pkg::PH_DONE) begin
                res.status = tidsd_pkg::ST_OK;
            end else begin
                res.status = tidsd_pkg::ST_TRUNCATED;
            end
        end
    end

    // Control state; the final beat returns the parser to its reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= tidsd_pkg::PH_HEAD;
            r_pos       <= '0;
            r_shift     <= '0;
            r_fields    <= '0;
            r_names     <= '0;
            r_values    <= '0;
            r_resids    <= '0;
            r_cur       <= '0;
            r_err       <= tidsd_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_out_valid <= emit || last;
                if (last) begin
                    r_phase  <= tidsd_pkg::PH_HEAD;
                    r_pos    <= '0;
                    r_shift  <= '0;
                    r_fields <= '0;
                    r_names  <= '0;
                    r_values <= '0;
                    r_resids <= '0;
                    r_cur    <= '0;
                    r_err    <= tidsd_pkg::ST_OK;
                end else begin
                    r_phase  <= n_phase;
                    r_pos    <= n_pos;
                    r_shift  <= n_shift;
                    r_fields <= n_fields;
                    r_names  <= n_names;
                    r_values <= n_values;
                    r_resids <= n_resids;
                    r_cur    <= n_cur;
                    r_err    <= n_err;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Held value words and result payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_hsec <= n_hsec;
            r_hnan <= n_hnan;
            r_out  <= res;
        end
    end

    // Result port
    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_out.kind;
    assign o_out.field_number = r_out.field_number;
    assign o_out.name_char    = r_out.name_char;
    assign o_out.seconds      = r_out.seconds;
    assign o_out.nanos        = r_out.nanos;
    assign o_out.document     = r_out.document;
    assign o_out.done_res     = r_out.done_res;
    assign o_out.status       = r_out.status;

    // Checks
    `TIDSD_ASSERT_NEXT(a_error_silent, i_clk, i_rst_n, step && r_phase == tidsd_pkg::PH_ERROR, !r_out_valid || r_out.kind == tidsd_pkg::KIND_STATUS, "record emitted after an error")
    `TIDSD_ASSERT_NEXT(a_last_reports, i_clk, i_rst_n, step && last, r_out_valid && r_out.done_res, "final beat gave no status result")
    `TIDSD_ASSERT_SAME(a_nanos_range, i_clk, i_rst_n, r_out_valid && r_out.kind == tidsd_pkg::KIND_VALUE, {2'b00, r_out.nanos} <= tidsd_pkg::NANO_MAX, "value record with nanosecond out of range")

endmodule

>>> hw/rtl/temporal_index_stream_decoder_unit.sv
// Top level of the temporal index stream decoder: input queue and parser
// Path: an accepted beat is written into the input queue, and its result, if any, into the
// result register, which drives the port.
// Throughput: one byte per cycle; a stalled result port fills the QueueDepth-beat queue.
// Reset (synchronous, active low) empties the queue, drops any pending result and returns
// the parser to the magic phase; the final byte of a buffer also resets the parser.
module temporal_index_stream_decoder_unit #(
    parameter int QueueDepth = tidsd_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tidsd_in_if.sink    i_in,
    tidsd_out_if.source o_out
);

    tidsd_pkg::t_queue_head head;
    logic                   pop;

    tidsd_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (pop),
        .o_head  (head)
    );

    tidsd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
